>>> hw/rtl/tsmp_pkg.sv
// Shared types and constants for the time string to milliseconds parser.
package tsmp_pkg;

    // Character codes recognized by the parser
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // Group and scaling constants
    localparam logic [9:0]  GROUP_MAX     = 10'd59;
    localparam logic [25:0] MS_PER_HOUR   = 26'd3600000;
    localparam logic [25:0] MS_PER_MINUTE = 26'd60000;
    localparam logic [25:0] MS_PER_SECOND = 26'd1000;
    localparam logic [25:0] MS_MAX        = 26'd35999999;

    localparam int MS_W = 26;

    // Parse state of one string, also handed over as a snapshot at its end
    typedef struct packed {
        logic [2:0][5:0] group_values;
        logic [2:0][1:0] group_counts;
        logic [1:0]      colon_count;
        logic [9:0]      frac_value;
        logic [1:0]      frac_count;
        logic            in_fraction;
        logic            error_seen;
    } parse_state_t;

endpackage

>>> hw/rtl/tsmp_parse.sv
// Input register and per-character parse state update.
module tsmp_parse
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_ready,
    input  logic [7:0]              character,
    input  logic                    last,
    output logic                    snap_valid,
    input  logic                    snap_ready,
    output tsmp_pkg::parse_state_t  snap
);

    logic                   valid0_reg;
    logic [7:0]             char0_reg;
    logic                   last0_reg;
    logic                   adv0;
    tsmp_pkg::parse_state_t state_reg;
    tsmp_pkg::parse_state_t state_next;
    tsmp_pkg::parse_state_t snap_reg;
    logic                   snap_valid_reg;

    // A buffered character moves on unless it ends a string and the snapshot is blocked
    assign adv0       = valid0_reg && (!last0_reg || !snap_valid_reg || snap_ready);
    assign char_ready = !valid0_reg || adv0;

    // Hold the accepted character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            valid0_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            char0_reg <= character;
            last0_reg <= last;
        end
    end

    // Apply one character to the parse state
    always_comb
    begin
        logic [1:0] gsel;
        logic [5:0] gval;
        logic [1:0] gcnt;
        logic [3:0] digit;
        logic [9:0] group_sum;
        logic [9:0] frac_sum;

        state_next = state_reg;
        gsel       = state_reg.colon_count;
        gval       = state_reg.group_values[gsel];
        gcnt       = state_reg.group_counts[gsel];
        digit      = 4'(char0_reg - tsmp_pkg::CHAR_ZERO);
        group_sum  = 10'({4'd0, gval} * 10'd10) + {6'd0, digit};
        frac_sum   = 10'(state_reg.frac_value * 10'd10) + {6'd0, digit};

        if (!state_reg.error_seen)
        begin
            if (char0_reg >= tsmp_pkg::CHAR_ZERO && char0_reg <= tsmp_pkg::CHAR_NINE)
            begin
                if (state_reg.in_fraction)
                begin
                    if (state_reg.frac_count == 2'd3)
                    begin
                        state_next.error_seen = 1'b1;
                    end
                    else
                    begin
                        state_next.frac_value = frac_sum;
                        state_next.frac_count = state_reg.frac_count + 2'd1;
                    end
                end
                else if (gcnt >= 2'd2 || group_sum > tsmp_pkg::GROUP_MAX)
                begin
                    state_next.error_seen = 1'b1;
                end
                else
                begin
                    state_next.group_values[gsel] = group_sum[5:0];
                    state_next.group_counts[gsel] = gcnt + 2'd1;
                end
            end
            else if (char0_reg == tsmp_pkg::CHAR_COLON)
            begin
                if (state_reg.in_fraction || state_reg.colon_count >= 2'd2 || gcnt == 2'd0)
                begin
                    state_next.error_seen = 1'b1;
                end
                else
                begin
                    state_next.colon_count = state_reg.colon_count + 2'd1;
                end
            end
            else if (char0_reg == tsmp_pkg::CHAR_DOT)
            begin
                if (state_reg.in_fraction || gcnt == 2'd0)
                begin
                    state_next.error_seen = 1'b1;
                end
                else
                begin
                    state_next.in_fraction = 1'b1;
                end
            end
            else
            begin
                state_next.error_seen = 1'b1;
            end
        end
    end

    // Advance the parse state; clear it after the last character of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (adv0)
        begin
            state_reg <= last0_reg ? '0 : state_next;
        end
    end

    // Hand the finished string over to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (adv0 && last0_reg)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0 && last0_reg)
        begin
            snap_reg <= state_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

>>> hw/rtl/tsmp_total.sv
// Form check, millisecond total and result register.
module tsmp_total
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            snap_valid,
    output logic                            snap_ready,
    input  tsmp_pkg::parse_state_t          snap,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [tsmp_pkg::MS_W-1:0]       milliseconds,
    output logic                            format_error,
    output logic                            classified
);

    logic                       result_valid_reg;
    logic [tsmp_pkg::MS_W-1:0]  milliseconds_reg;
    logic                       format_error_reg;
    logic                       classified_reg;
    logic                       ok;
    logic [tsmp_pkg::MS_W-1:0]  total;

    assign snap_ready = !result_valid_reg || result_ready;

    // Check the string against the three accepted forms
    always_comb
    begin
        ok = 1'b0;
        if (!snap.error_seen && !(snap.in_fraction && snap.frac_count == 2'd0))
        begin
            case (snap.colon_count)
                2'd0:    ok = snap.group_counts[0] != 2'd0;
                2'd1:    ok = snap.group_counts[0] != 2'd0 && snap.group_counts[1] == 2'd2;
                2'd2:    ok = snap.group_counts[0] == 2'd1 && snap.group_counts[1] == 2'd2
                              && snap.group_counts[2] == 2'd2;
                default: ok = 1'b0;
            endcase
        end
    end

    // Sum the scaled groups and the fraction
    always_comb
    begin
        logic [5:0]                 hours;
        logic [5:0]                 minutes;
        logic [5:0]                 seconds;
        logic [tsmp_pkg::MS_W-1:0]  frac;

        hours   = 6'd0;
        minutes = 6'd0;
        seconds = 6'd0;
        case (snap.colon_count)
            2'd0:
            begin
                seconds = snap.group_values[0];
            end
            2'd1:
            begin
                minutes = snap.group_values[0];
                seconds = snap.group_values[1];
            end
            default:
            begin
                hours   = snap.group_values[0];
                minutes = snap.group_values[1];
                seconds = snap.group_values[2];
            end
        endcase

        frac = '0;
        if (snap.in_fraction)
        begin
            case (snap.frac_count)
                2'd1:    frac = 26'({16'd0, snap.frac_value} * 26'd100);
                2'd2:    frac = 26'({16'd0, snap.frac_value} * 26'd10);
                default: frac = {16'd0, snap.frac_value};
            endcase
        end

        total = 26'({20'd0, hours} * tsmp_pkg::MS_PER_HOUR)
              + 26'({20'd0, minutes} * tsmp_pkg::MS_PER_MINUTE)
              + 26'({20'd0, seconds} * tsmp_pkg::MS_PER_SECOND)
              + frac;
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            result_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
        begin
            milliseconds_reg <= ok ? total : '0;
            format_error_reg <= !ok;
            classified_reg   <= ok && (total != '0);
        end
    end

    assign result_valid = result_valid_reg;
    assign milliseconds = milliseconds_reg;
    assign format_error = format_error_reg;
    assign classified   = classified_reg;

endmodule

>>> hw/rtl/time_string_to_millis_parser.sv
// Top level of the time string to milliseconds parser.
//
// Characters of a time string (S[.f], M:SS[.f] or H:MM:SS[.f]) enter on the
// character channel, one per transfer, with last set on the final one. Each
// string yields exactly one transfer on the result channel: the duration in
// milliseconds, a format error flag and a classified flag (valid, nonzero).
// Characters without last produce nothing on the result channel.
// Throughput: one character per cycle. A character sits in the input
// register while the parse state updates; a string's result passes from
// the input register through the snapshot to the result register. While
// the receiver stalls, a finished string waits in the result register and
// a second one in the snapshot; characters of the next string keep
// flowing, and only a further last character is held back. Reset clears
// the parse state and empties all stages; the block is ready as soon as
// reset is released.
module time_string_to_millis_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        char_valid,
    output logic                        char_ready,
    input  logic [7:0]                  character,
    input  logic                        last,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [tsmp_pkg::MS_W-1:0]   milliseconds,
    output logic                        format_error,
    output logic                        classified
);

    tsmp_pkg::parse_state_t snap;
    logic                   snap_valid;
    logic                   snap_ready;

    tsmp_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .character  (character),
        .last       (last),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    tsmp_total u_total
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (snap_valid),
        .snap_ready   (snap_ready),
        .snap         (snap),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .milliseconds (milliseconds),
        .format_error (format_error),
        .classified   (classified)
    );

endmodule

>>> hw/rtl/tsmp_checker.sv
// Port-level checks for the time string to milliseconds parser, bound to the top level.
module tsmp_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic [tsmp_pkg::MS_W-1:0]   milliseconds,
    input  logic                        format_error,
    input  logic                        classified
);

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(milliseconds)
            && $stable(format_error) && $stable(classified))
        else $error("stalled result changed");

    // An error reports a zero duration and is never classified
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && format_error |-> milliseconds == '0 && !classified)
        else $error("error result carries a duration or class");

    // Classified exactly when valid and nonzero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> classified == (!format_error && milliseconds != '0))
        else $error("classified flag mismatch");

    // A duration never exceeds 9:59:59.999
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> milliseconds <= tsmp_pkg::MS_MAX)
        else $error("duration out of range");

endmodule

bind time_string_to_millis_parser tsmp_checker u_tsmp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .milliseconds (milliseconds),
    .format_error (format_error),
    .classified   (classified)
);
